[design/aes_kx_pkg.sv]
package aes_kx_pkg;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  key_len;
    } t_in_req;

    typedef struct packed {
        logic [3:0]  round_index;
        logic [63:0] round_key_high;
        logic [63:0] round_key_low;
        logic        accepted;
        logic        last;
    } t_out_req;

    // controller to datapath
    typedef struct packed {
        logic load;     // take the key into the working register
        logic advance;  // expand one round
    } t_kx_cmd;

    localparam logic [7:0] KEY_LEN_BYTES = 8'd16;
    localparam logic [3:0] LAST_ROUND    = 4'd10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // round constants, indexed by the round being produced minus one
    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

endpackage

[design/aes_kx_datapath.sv]
module aes_kx_datapath (
    input  logic                 i_clk,
    input  aes_kx_pkg::t_kx_cmd  i_cmd,
    input  logic [3:0]           i_round,
    input  logic [63:0]          i_key_high,
    input  logic [63:0]          i_key_low,
    output logic [127:0]         o_round_key
);
    import aes_kx_pkg::*;

    logic [127:0] r_key;
    logic [127:0] n_key;
    logic [31:0]  w0, w1, w2, w3, rot, sub;
    logic [3:0]   rc_idx;

    assign {w0, w1, w2, w3} = r_key;
    assign rot    = {w3[23:0], w3[31:24]};
    // i_round is the key now held; the next one uses rcon of that index
    assign rc_idx = (i_round > 4'd9) ? 4'd0 : i_round;

    // sub word through the s-box
    assign sub = {SBOX[rot[31:24]] ^ RCON[rc_idx], SBOX[rot[23:16]],
                  SBOX[rot[15:8]], SBOX[rot[7:0]]};

    // load the input key, or expand one round of the schedule
    always_comb begin
        logic [31:0] a, b, c, d;
        a = w0 ^ sub;
        b = w1 ^ a;
        c = w2 ^ b;
        d = w3 ^ c;
        n_key = r_key;
        if (i_cmd.load) begin
            n_key = {i_key_high, i_key_low};
        end else if (i_cmd.advance) begin
            n_key = {a, b, c, d};
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_round_key = r_key;
endmodule

[design/aes_kx_ctrl.sv]
module aes_kx_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_key_len,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output logic                 o_accepted,
    output logic [3:0]           o_round,
    output aes_kx_pkg::t_kx_cmd  o_cmd
);
    import aes_kx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;

    logic [1:0] r_state, n_state;
    logic [3:0] r_round, n_round;
    logic       r_acc, n_acc;
    logic       take, give, fin;

    assign take = i_in_valid && (r_state == S_IDLE);
    assign give = (r_state == S_EMIT) && !i_out_stall;
    assign fin  = !r_acc || (r_round == LAST_ROUND);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_acc   = r_acc;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_EMIT;
                    n_round    = '0;
                    n_acc      = (i_key_len == KEY_LEN_BYTES);
                    o_cmd.load = 1'b1;
                end
            end
            S_EMIT: begin
                if (give) begin
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_round       = r_round + 4'd1;
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_acc   <= n_acc;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_accepted  = r_acc;
    assign o_round     = r_round;

    // round never passes the last key
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= LAST_ROUND) else $error("round out of range");
    // a rejected key gives exactly one request
    a_reject_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (give && !r_acc) |=> (r_state == S_IDLE)) else $error("reject not single");
    // load happens only when an input is taken in idle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> take) else $error("stray load");
endmodule

[design/aes128_key_expansion.sv]
// channel | direction | handshake          | payload
// in      | input     | i_in_valid/o_in_stall  | t_in_req
// out     | output    | o_out_valid/i_out_stall | t_out_req
// one key is loaded, then one round key per cycle unless stalled (11 results),
// set by the single round unit that expands one round per cycle.
// a wrong key length gives a single result.
// reset clears the controller; an output stall holds the current round key.
module aes128_key_expansion (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  aes_kx_pkg::t_in_req   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output aes_kx_pkg::t_out_req  o_out_data
);
    import aes_kx_pkg::*;

    t_kx_cmd      cmd;
    logic [3:0]   round;
    logic         acc;
    logic [127:0] rk;

    aes_kx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_key_len   (i_in_data.key_len),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_accepted  (acc),
        .o_round     (round),
        .o_cmd       (cmd)
    );

    aes_kx_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_round     (round),
        .i_key_high  (i_in_data.key_high),
        .i_key_low   (i_in_data.key_low),
        .o_round_key (rk)
    );

    // rejected keys report zeros
    assign o_out_data.round_index    = acc ? round : 4'd0;
    assign o_out_data.round_key_high = acc ? rk[127:64] : 64'd0;
    assign o_out_data.round_key_low  = acc ? rk[63:0] : 64'd0;
    assign o_out_data.accepted       = acc;
    assign o_out_data.last           = !acc || (round == LAST_ROUND);
endmodule
